// ===== rtl/floored_signed_div_mod_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Floored signed div/mod assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FLOORED_SIGNED_DIV_MOD_UNIT_ASSERT_SVH
`define FLOORED_SIGNED_DIV_MOD_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked while the block is out of reset.
`define FSDM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fsdm assertion failed");
// Property that also holds during reset.
`define FSDM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fsdm reset assertion failed");
`else
`define FSDM_ASSERT(lbl, clk, rst, prop)
`define FSDM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/fsdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Floored signed div/mod package
// Item types of both channels and the flags that travel down the divider.
// ----------------------------------------------------------------------------
package fsdm_pkg;

  localparam int FIELD_W = 64;

  typedef struct packed {
    logic signed [FIELD_W-1:0] dividend;
    logic signed [FIELD_W-1:0] divisor;
  } fsdm_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] quotient;
    logic signed [FIELD_W-1:0] remainder;
    logic                      divide_by_zero;
    logic                      overflow;
  } fsdm_rsp_t;

  // Per-item side information carried alongside the magnitudes.
  typedef struct packed {
    logic neg_dividend;
    logic neg_divisor;
    logic div_zero;
    logic ovf;
  } fsdm_flags_t;

endpackage

// ===== rtl/fsdm_prep.sv =====
// ----------------------------------------------------------------------------
// Floored signed div/mod input stage
// Takes the signs apart, forms both magnitudes and detects the special cases.
// ----------------------------------------------------------------------------
module fsdm_prep #(
  parameter int WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  fsdm_pkg::fsdm_req_t   up_item,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [WIDTH-1:0]      dn_quo,
  output logic [WIDTH-1:0]      dn_dvs,
  output fsdm_pkg::fsdm_flags_t dn_flags
);

  localparam logic [WIDTH-1:0] MIN_VAL = {1'b1, {(WIDTH-1){1'b0}}};

  logic                  valid;
  logic [WIDTH-1:0]      mag_a;
  logic [WIDTH-1:0]      mag_b;
  fsdm_pkg::fsdm_flags_t flags;

  logic [WIDTH-1:0]      a_w;
  logic [WIDTH-1:0]      b_w;
  logic [WIDTH-1:0]      mag_a_next;
  logic [WIDTH-1:0]      mag_b_next;
  fsdm_pkg::fsdm_flags_t flags_next;

  // Only the low WIDTH bits of each field take part.
  assign a_w = up_item.dividend[WIDTH-1:0];
  assign b_w = up_item.divisor[WIDTH-1:0];

  always_comb begin
    mag_a_next              = a_w[WIDTH-1] ? (~a_w + 1'b1) : a_w;
    mag_b_next              = b_w[WIDTH-1] ? (~b_w + 1'b1) : b_w;
    flags_next.neg_dividend = a_w[WIDTH-1];
    flags_next.neg_divisor  = b_w[WIDTH-1];
    flags_next.div_zero     = (b_w == '0);
    flags_next.ovf          = (a_w == MIN_VAL) && (b_w == '1);
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_valid && up_ready) begin
      mag_a <= mag_a_next;
      mag_b <= mag_b_next;
      flags <= flags_next;
    end
  end

  assign dn_valid = valid;
  assign dn_quo   = mag_a;
  assign dn_dvs   = mag_b;
  assign dn_flags = flags;

endmodule

// ===== rtl/fsdm_cell.sv =====
// ----------------------------------------------------------------------------
// Floored signed div/mod divider cell
// One restoring step on unsigned magnitudes, registered with its own valid.
// ----------------------------------------------------------------------------
module fsdm_cell #(
  parameter int WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [WIDTH-1:0]      up_rem,
  input  logic [WIDTH-1:0]      up_quo,
  input  logic [WIDTH-1:0]      up_dvs,
  input  fsdm_pkg::fsdm_flags_t up_flags,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output logic [WIDTH-1:0]      dn_rem,
  output logic [WIDTH-1:0]      dn_quo,
  output logic [WIDTH-1:0]      dn_dvs,
  output fsdm_pkg::fsdm_flags_t dn_flags
);

  logic                  valid;
  logic [WIDTH-1:0]      rem;
  logic [WIDTH-1:0]      quo;
  logic [WIDTH-1:0]      dvs;
  fsdm_pkg::fsdm_flags_t flags;

  logic [WIDTH:0]        shifted;
  logic [WIDTH:0]        diff;
  logic [WIDTH-1:0]      rem_next;
  logic [WIDTH-1:0]      quo_next;

  // Shift in the next dividend bit, then try to subtract the divisor.
  // The partial remainder stays below the divisor, so WIDTH+1 bits hold it.
  always_comb begin
    shifted  = {up_rem, up_quo[WIDTH-1]};
    diff     = shifted - {1'b0, up_dvs};
    quo_next = {up_quo[WIDTH-2:0], !diff[WIDTH]};
    rem_next = diff[WIDTH] ? shifted[WIDTH-1:0] : diff[WIDTH-1:0];
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_valid && up_ready) begin
      rem   <= rem_next;
      quo   <= quo_next;
      dvs   <= up_dvs;
      flags <= up_flags;
    end
  end

  assign dn_valid = valid;
  assign dn_rem   = rem;
  assign dn_quo   = quo;
  assign dn_dvs   = dvs;
  assign dn_flags = flags;

endmodule

// ===== rtl/fsdm_fix.sv =====
// ----------------------------------------------------------------------------
// Floored signed div/mod output stage
// Applies floor correction and signs, settles special cases, holds the result.
// ----------------------------------------------------------------------------
module fsdm_fix #(
  parameter int WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [WIDTH-1:0]      up_rem,
  input  logic [WIDTH-1:0]      up_quo,
  input  logic [WIDTH-1:0]      up_dvs,
  input  fsdm_pkg::fsdm_flags_t up_flags,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output fsdm_pkg::fsdm_rsp_t   dn_item
);

  localparam int FW = fsdm_pkg::FIELD_W;

  logic                valid;
  fsdm_pkg::fsdm_rsp_t item;

  logic                signs_differ;
  logic                adjust;
  logic [WIDTH-1:0]    q_val;
  logic [WIDTH-1:0]    r_val;
  fsdm_pkg::fsdm_rsp_t item_next;

  // Rounding toward minus infinity: when the signs differ and the magnitude
  // division leaves a remainder, the quotient magnitude grows by one, so the
  // negated quotient becomes ~mq, and the remainder becomes mb - mr with the divisor's sign.
  always_comb begin
    signs_differ = up_flags.neg_dividend ^ up_flags.neg_divisor;
    adjust       = signs_differ && (up_rem != '0);

    if (up_flags.div_zero) begin
      q_val = '0;
    end else if (adjust) begin
      q_val = ~up_quo;
    end else if (signs_differ) begin
      q_val = ~up_quo + 1'b1;
    end else begin
      q_val = up_quo;
    end

    if (up_flags.div_zero || up_flags.ovf) begin
      r_val = '0;
    end else if (adjust) begin
      r_val = up_flags.neg_divisor ? (up_rem - up_dvs) : (up_dvs - up_rem);
    end else begin
      r_val = up_flags.neg_divisor ? (~up_rem + 1'b1) : up_rem;
    end

    item_next.quotient       = FW'($signed(q_val));
    item_next.remainder      = FW'($signed(r_val));
    item_next.divide_by_zero = up_flags.div_zero;
    item_next.overflow       = up_flags.ovf;
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
    if (up_valid && up_ready) begin
      item <= item_next;
    end
  end

  assign dn_valid = valid;
  assign dn_item  = item;

endmodule

// ===== rtl/floored_signed_div_mod_unit.sv =====
// An accepted item is registered in the input stage, in each of the WIDTH cells and in the output stage on its way.
// Throughput: one item per cycle while the output is not stalled; each stage of the WIDTH-cell divider chain
// holds one item and frees itself as soon as its neighbor downstream takes it.
// Reset (rst, synchronous, active high) empties every stage; the block keeps
// no other state, so no item survives reset.
// ----------------------------------------------------------------------------
// Floored signed division and modulo unit
// Pipelined restoring array divider with an input stage and an output stage.
// ----------------------------------------------------------------------------
`include "floored_signed_div_mod_unit_assert.svh"

module floored_signed_div_mod_unit #(
  parameter int WIDTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fsdm_pkg::fsdm_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output fsdm_pkg::fsdm_rsp_t rsp
);

  // The input stage turns both operands into unsigned magnitudes and records
  // their signs along with the zero divisor and overflow cases. Then WIDTH
  // identical cells each produce one quotient bit, most significant first,
  // passing partial remainder, shifting dividend/quotient word, divisor and
  // flags to the next cell. The output stage corrects the magnitude result
  // toward minus infinity, applies signs, sign-extends to the 64-bit fields
  // and keeps the finished item in a register until it is taken.
  //
  // Every stage carries its own valid bit and is ready when empty or when
  // its neighbor downstream is ready, so bubbles close up and a new item is
  // accepted while a finished one is still waiting at the output.

  logic                  chain_valid [0:WIDTH];
  logic                  chain_ready [0:WIDTH];
  logic [WIDTH-1:0]      chain_rem   [0:WIDTH];
  logic [WIDTH-1:0]      chain_quo   [0:WIDTH];
  logic [WIDTH-1:0]      chain_dvs   [0:WIDTH];
  fsdm_pkg::fsdm_flags_t chain_flags [0:WIDTH];

  fsdm_prep #(
    .WIDTH (WIDTH)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (req_valid),
    .up_ready (req_ready),
    .up_item  (req),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_quo   (chain_quo[0]),
    .dn_dvs   (chain_dvs[0]),
    .dn_flags (chain_flags[0])
  );

  // The partial remainder starts at zero in front of the first cell.
  assign chain_rem[0] = '0;

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    fsdm_cell #(
      .WIDTH (WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_rem   (chain_rem[i]),
      .up_quo   (chain_quo[i]),
      .up_dvs   (chain_dvs[i]),
      .up_flags (chain_flags[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_rem   (chain_rem[i+1]),
      .dn_quo   (chain_quo[i+1]),
      .dn_dvs   (chain_dvs[i+1]),
      .dn_flags (chain_flags[i+1])
    );
  end

  fsdm_fix #(
    .WIDTH (WIDTH)
  ) u_fix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (chain_valid[WIDTH]),
    .up_ready (chain_ready[WIDTH]),
    .up_rem   (chain_rem[WIDTH]),
    .up_quo   (chain_quo[WIDTH]),
    .up_dvs   (chain_dvs[WIDTH]),
    .up_flags (chain_flags[WIDTH]),
    .dn_valid (rsp_valid),
    .dn_ready (rsp_ready),
    .dn_item  (rsp)
  );

  // A zero divisor gives zero results and never counts as overflow.
  `FSDM_ASSERT(a_dz_zero, clk, rst, rsp_valid && rsp.divide_by_zero |-> rsp.quotient == '0 && rsp.remainder == '0 && !rsp.overflow)
  // Overflow wraps the quotient to the most negative value with no remainder.
  `FSDM_ASSERT(a_ovf_result, clk, rst, rsp_valid && rsp.overflow |-> rsp.remainder == '0 && rsp.quotient[WIDTH-1] && rsp.quotient[WIDTH-2:0] == '0)
  // Input back-pressure only arises from a full chain behind a stalled output.
  `FSDM_ASSERT(a_stall_source, clk, rst, !req_ready |-> rsp_valid && !rsp_ready)
  // Results are sign-extended from bit WIDTH-1 into the 64-bit fields.
  `FSDM_ASSERT(a_sign_ext, clk, rst, rsp_valid |-> $signed(rsp.quotient) == $signed(rsp.quotient[WIDTH-1:0]) && $signed(rsp.remainder) == $signed(rsp.remainder[WIDTH-1:0]))
  // Reset leaves no result behind.
  `FSDM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !rsp_valid)

endmodule
